// ----- rtl/mmnb_pkg.sv -----
package mmnb_pkg;

	// Result byte width and its full-scale code
	localparam int PIXEL_BITS = 8;
	localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = 8'd255;

	// Values of the cmd field
	localparam logic CMD_SCAN    = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic scan_en;   // fold the incoming sample into min and max
		logic cap_en;    // capture the incoming sample for a convert
		logic prep_en;   // register offset and range
		logic mul_en;    // scale the offset by 255, settle the saturated cases
		logic div_en;    // one restoring division step
		logic load_en;   // move the quotient into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic sat;       // result is settled without a division
	} dp_stat_t;

endpackage

// ----- rtl/mmnb_datapath.sv -----
module mmnb_datapath #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mmnb_pkg::dp_cmd_t                   dp_cmd,
	output mmnb_pkg::dp_stat_t                  dp_stat,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                first,
	output logic [mmnb_pkg::PIXEL_BITS-1:0]     pixel
);

	localparam int PB = mmnb_pkg::PIXEL_BITS;
	localparam int DW = SAMPLE_BITS + 1;
	localparam int NW = SAMPLE_BITS + PB;

	logic signed [SAMPLE_BITS-1:0] min_q, max_q, smp_q;
	logic signed [DW-1:0]          diff_q, range_q;
	logic [NW-1:0]                 rem_q, den_q;
	logic [PB-1:0]                 quo_q, pixel_q;
	logic                          range_bad, diff_low, diff_high, ge;

	// Running minimum and maximum over the scan pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else if (dp_cmd.scan_en) begin
			if (first) begin
				min_q <= sample;
				max_q <= sample;
			end else begin
				if (sample < min_q) min_q <= sample;
				if (sample > max_q) max_q <= sample;
			end
		end
	end

	// Saturation checks on the registered offset and range
	assign range_bad = range_q[DW-1] || (range_q == '0);
	assign diff_low  = diff_q[DW-1] || (diff_q == '0);
	assign diff_high = (diff_q >= range_q);
	assign dp_stat.sat = range_bad || diff_low || diff_high;

	assign ge = (rem_q >= den_q);

	// Convert path: offset, scale, restoring division, output byte
	always_ff @(posedge clk) begin
		if (dp_cmd.cap_en)
			smp_q <= sample;
		if (dp_cmd.prep_en) begin
			diff_q  <= {smp_q[SAMPLE_BITS-1], smp_q} - {min_q[SAMPLE_BITS-1], min_q};
			range_q <= {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};
		end
		if (dp_cmd.mul_en) begin
			// 255 * diff as (diff << 8) - diff; diff is positive whenever a division follows
			rem_q <= {diff_q[SAMPLE_BITS-1:0], {PB{1'b0}}}
				- {{PB{1'b0}}, diff_q[SAMPLE_BITS-1:0]};
			den_q <= {1'b0, range_q[SAMPLE_BITS-1:0], {(PB-1){1'b0}}};
			if (range_bad || diff_low)
				quo_q <= '0;
			else
				quo_q <= mmnb_pkg::PIXEL_MAX;
		end
		if (dp_cmd.div_en) begin
			if (ge) rem_q <= rem_q - den_q;
			den_q <= den_q >> 1;
			quo_q <= {quo_q[PB-2:0], ge};
		end
		if (dp_cmd.load_en)
			pixel_q <= quo_q;
	end

	assign pixel = pixel_q;

`ifndef ASSERT_OFF
	// After any scan the range is ordered
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.scan_en |=> (min_q <= max_q))
		else $error("running min above running max after scan");

	// Division only runs on a positive range
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.div_en |-> (!range_q[DW-1] && (range_q != '0)))
		else $error("division step with empty range");
`endif

endmodule

// ----- rtl/mmnb_ctrl.sv -----
module mmnb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output mmnb_pkg::dp_cmd_t   dp_cmd,
	input  mmnb_pkg::dp_stat_t  dp_stat
);

	localparam int CW = $clog2(mmnb_pkg::PIXEL_BITS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          in_acc, out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Datapath commands per state
	always_comb begin
		dp_cmd         = '0;
		dp_cmd.scan_en = in_acc && (cmd == mmnb_pkg::CMD_SCAN);
		dp_cmd.cap_en  = in_acc && (cmd == mmnb_pkg::CMD_CONVERT);
		dp_cmd.prep_en = (state_q == S_PREP);
		dp_cmd.mul_en  = (state_q == S_MUL);
		dp_cmd.div_en  = (state_q == S_DIV);
		dp_cmd.load_en = (state_q == S_LOAD) && out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (cmd == mmnb_pkg::CMD_CONVERT)) state_d = S_PREP;
			end
			S_PREP: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = dp_stat.sat ? S_LOAD : S_DIV;
			end
			S_DIV: begin
				if (cnt_q == '0) state_d = S_LOAD;
			end
			S_LOAD: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Step counter over the quotient bits
			if (state_q == S_MUL)
				cnt_q <= CW'(mmnb_pkg::PIXEL_BITS - 1);
			else if (state_q == S_DIV)
				cnt_q <= cnt_q - 1'b1;
			// Output register valid
			if (dp_cmd.load_en)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_conv_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == mmnb_pkg::CMD_CONVERT)) |=> (state_q == S_PREP))
		else $error("convert transaction did not start the sequence");

	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && (cnt_q == '0)) |=> (state_q == S_LOAD))
		else $error("division did not end after the last quotient bit");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_LOAD) && out_free) |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("result load did not raise out_valid");
`endif

endmodule

// ----- rtl/min_max_normalize_to_byte_core.sv -----
// Min-max normalization of samples to bytes, two passes.
// Input channel (in_valid / in_stall): cmd, sample, first. A scan transaction
// (cmd 0) folds sample into a running min and max; first restarts both from
// the sample. Scans give no result and are taken one per cycle outside a convert.
// A convert transaction (cmd 1) yields one output transaction (out_valid /
// out_stall) carrying pixel = floor(255*(sample-min)/(max-min)), saturated
// to 0 or 255; an empty or flat range gives 0.
// A convert steps through prep, scale, the 8-step restoring divider (one
// quotient bit per cycle) and load; a saturated result skips the divider.
// in_stall is high while a convert is in progress, so the input takes no
// other item until the convert has loaded its result.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls with the register full, a finished convert
// holds in its final step and the input stays stalled until the register frees.
// Reset clears min to the most positive and max to the most negative value,
// drops out_valid and returns the controller to idle.
module min_max_normalize_to_byte_core #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                first,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mmnb_pkg::PIXEL_BITS-1:0]     pixel
);

	mmnb_pkg::dp_cmd_t  dp_cmd;
	mmnb_pkg::dp_stat_t dp_stat;

	mmnb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	mmnb_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.dp_cmd  (dp_cmd),
		.dp_stat (dp_stat),
		.sample  (sample),
		.first   (first),
		.pixel   (pixel)
	);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int SMP_W        = 32;
	localparam int PX_W         = mmnb_pkg::PIXEL_BITS;
	localparam int N_ITEMS      = 1350;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_TAIL    = 150;

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	// One input transaction; drain makes the sender wait until no pixel is outstanding
	typedef struct {
		logic                    cmd;
		logic signed [SMP_W-1:0] sample;
		logic                    first;
		bit                      drain;
	} px_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = mmnb_pkg::CMD_SCAN;
	logic signed [SMP_W-1:0] sample = '0;
	logic first = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PX_W-1:0] pixel;

	px_item_t pending_items[$];
	px_item_t next_item;
	logic [PX_W-1:0] pixel_due[$];
	logic [PX_W-1:0] want_px;

	// Predicted running range
	logic signed [SMP_W-1:0] span_lo = SMP_MAX;
	logic signed [SMP_W-1:0] span_hi = SMP_MIN;

	bit in_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int long_hold_left = 0;
	bit long_hold_done = 1'b0;
	int n_total = 0;
	int n_accepted = 0;
	int n_scans = 0;
	int n_converts = 0;
	int n_checked = 0;
	int n_drains = 0;
	int n_err = 0;
	int unsigned cycles = 0;

	min_max_normalize_to_byte_core #(.SAMPLE_BITS(SMP_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sample   (sample),
		.first    (first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel    (pixel)
	);

	always #5 clk = ~clk;

	// Timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycles, pixel_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		n_err++;
		if (n_err <= 30)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Expected byte for a convert against the current range
	function automatic logic [PX_W-1:0] scaled_pixel(logic signed [SMP_W-1:0] s);
		longint lo, hi, v, range, diff;
		lo = span_lo;
		hi = span_hi;
		v = s;
		range = hi - lo;
		if (range <= 0)
			return '0;
		diff = v - lo;
		if (diff <= 0)
			return '0;
		if (diff >= range)
			return mmnb_pkg::PIXEL_MAX;
		return PX_W'((diff * 255) / range);
	endfunction

	// Idle bursts are off in the tail and in every fourth window of 120 transactions
	function automatic bit idling_ok();
		return (n_accepted < n_total - CALM_TAIL) && ((n_accepted / 120) % 4 != 3);
	endfunction

	function automatic void add_item(logic c, logic signed [SMP_W-1:0] s, logic f, bit d);
		px_item_t it;
		it.cmd = c;
		it.sample = s;
		it.first = f;
		it.drain = d;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Sample draw: 0 full random, 1 near center, 2 extremes, 3 center only (flat)
	function automatic logic signed [SMP_W-1:0] draw_sample(int mode,
			logic signed [SMP_W-1:0] ctr);
		case (mode)
			0: return $urandom;
			1: return ctr + ($urandom_range(0, 64) - 32);
			2: begin
				case ($urandom_range(0, 4))
					0: return SMP_MAX;
					1: return SMP_MIN;
					2: return '0;
					3: return '1;
					default: return ctr;
				endcase
			end
			default: return ctr;
		endcase
	endfunction

	// Stimulus and end of run
	initial begin
		int seq_cnt;
		int mode;
		int r;
		longint lo, hi, span, v;
		logic signed [SMP_W-1:0] ctr, s;

		// Convert before any scan: empty range
		add_item(mmnb_pkg::CMD_CONVERT, '0, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, SMP_MAX, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, SMP_MIN, 1'b1, 1'b0);
		// Flat range
		add_item(mmnb_pkg::CMD_SCAN, '0, 1'b1, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, '0, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, 32'sd1, 1'b0, 1'b0);
		// Full range, extremes of the sample
		add_item(mmnb_pkg::CMD_SCAN, SMP_MIN, 1'b1, 1'b0);
		add_item(mmnb_pkg::CMD_SCAN, SMP_MAX, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, SMP_MIN, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, SMP_MAX, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, '0, 1'b1, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, '1, 1'b0, 1'b0);
		// Restart to a small range; below, inside, at and above the bounds
		add_item(mmnb_pkg::CMD_SCAN, 32'sd100, 1'b1, 1'b1);
		add_item(mmnb_pkg::CMD_SCAN, 32'sd200, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, 32'sd50, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, 32'sd100, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, 32'sd150, 1'b1, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, 32'sd199, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, 32'sd200, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, 32'sd250, 1'b0, 1'b0);
		// Negative range
		add_item(mmnb_pkg::CMD_SCAN, -32'sd5, 1'b1, 1'b0);
		add_item(mmnb_pkg::CMD_SCAN, -32'sd3, 1'b0, 1'b0);
		add_item(mmnb_pkg::CMD_CONVERT, -32'sd4, 1'b0, 1'b0);

		// Random sequences: restart, scans, then converts around the range
		seq_cnt = 0;
		lo = -5;
		hi = -3;
		while (pending_items.size() < N_ITEMS) begin
			mode = $urandom_range(0, 3);
			ctr = $urandom;
			s = draw_sample(mode, ctr);
			if ($urandom_range(0, 7) == 0) begin
				// broken sequence: no restart, range carries over
				add_item(mmnb_pkg::CMD_SCAN, s, 1'b0, seq_cnt % 12 == 0);
				if (s < lo) lo = s;
				if (s > hi) hi = s;
			end else begin
				add_item(mmnb_pkg::CMD_SCAN, s, 1'b1, seq_cnt % 12 == 0);
				lo = s;
				hi = s;
			end
			repeat ($urandom_range(0, 7)) begin
				s = draw_sample(mode, ctr);
				add_item(mmnb_pkg::CMD_SCAN, s, 1'b0, 1'b0);
				if (s < lo) lo = s;
				if (s > hi) hi = s;
			end
			repeat ($urandom_range(1, 10)) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					span = hi - lo + 1;
					v = lo + longint'({$urandom, $urandom} % span);
					s = v[SMP_W-1:0];
				end else if (r == 6)
					s = lo[SMP_W-1:0];
				else if (r == 7)
					s = hi[SMP_W-1:0];
				else if (r == 8)
					s = $urandom;
				else
					s = $urandom_range(0, 1) ? lo[SMP_W-1:0] - 1 : hi[SMP_W-1:0] + 1;
				add_item(mmnb_pkg::CMD_CONVERT, s, 1'($urandom_range(0, 1)), 1'b0);
			end
			seq_cnt++;
		end
		n_total = pending_items.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid || pixel_due.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		$display("%0d transactions in: %0d scans, %0d converts; %0d pixels checked",
			n_accepted, n_scans, n_converts, n_checked);
		$display("receiver held off %0d cycles once; sender drained %0d times; %0d mismatches",
			HOLD_CYCLES, n_drains, n_err);
		if (n_err == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Input driver: holds a stalled transaction, otherwise idles or offers the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// payload held
		end else if (send_gap != 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_items.size() == 0) begin
			in_valid <= 1'b0;
		end else if (pending_items[0].drain && pixel_due.size() != 0) begin
			in_valid <= 1'b0;
		end else if (idling_ok() && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			send_gap <= $urandom_range(0, 17);
		end else begin
			next_item = pending_items.pop_front();
			if (next_item.drain)
				n_drains++;
			in_valid <= 1'b1;
			cmd <= next_item.cmd;
			sample <= next_item.sample;
			first <= next_item.first;
		end
	end

	// Long receiver hold-off, once, while the sender keeps offering
	always @(negedge clk) begin
		if (long_hold_left != 0) begin
			long_hold_left <= long_hold_left - 1;
		end else if (!long_hold_done && n_accepted >= HOLD_AT) begin
			long_hold_left <= HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end
	end

	// Receiver stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (long_hold_left != 0) begin
			out_stall <= 1'b1;
		end else if (arst_n && idling_ok() && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: check pixels first, then fold accepted input into the prediction
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pixel_due.size() == 0) begin
					report_mismatch($sformatf("pixel %0d with no convert pending", pixel));
				end else begin
					want_px = pixel_due.pop_front();
					n_checked++;
					if (pixel !== want_px)
						report_mismatch($sformatf("pixel %0d, expected %0d (result %0d)",
							pixel, want_px, n_checked));
				end
			end
			if (in_valid && !in_stall) begin
				n_accepted++;
				if (cmd == mmnb_pkg::CMD_SCAN) begin
					n_scans++;
					if (first) begin
						span_lo = sample;
						span_hi = sample;
					end else begin
						if (sample < span_lo) span_lo = sample;
						if (sample > span_hi) span_hi = sample;
					end
				end else begin
					n_converts++;
					pixel_due.insert(pixel_due.size(), scaled_pixel(sample));
				end
			end
		end
	end

endmodule

// ----- filelist.f -----
rtl/mmnb_pkg.sv
rtl/mmnb_datapath.sv
rtl/mmnb_ctrl.sv
rtl/min_max_normalize_to_byte_core.sv
tb/sv/tb.sv
